>>> hw/rtl/smpq_pkg.sv
// Package for the sorted min priority queue: capacity, count width,
// operation and status codes, and the control word broadcast to the cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Control word seen by every cell in the same cycle
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/smpq_cell.sv
// One slot of the sorted chain: holds a value, reports whether it stays in
// place on a push, and takes from its left or right neighbor on a shift.
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell (
    input  wire logic                             aclk,
    input  wire smpq_pkg::cell_ctrl_t             ctrl,
    input  wire logic                             occupied,
    input  wire logic                             left_keep,
    input  wire logic signed [smpq_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [smpq_pkg::DATA_W-1:0] right_data,
    output logic signed [smpq_pkg::DATA_W-1:0]   data,
    output logic                                  keep
);
    import smpq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;

    // Values less than or equal to the new one stay ahead of it
    assign keep = occupied && (data_reg <= ctrl.value);
    assign data = data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.ins) begin
            if (!keep) begin
                data_reg <= left_keep ? ctrl.value : left_data;
            end
        end else if (ctrl.rem) begin
            data_reg <= right_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_min_priority_queue.sv
// Sorted min priority queue: a row of CAPACITY cells keeps signed 32-bit values
// in ascending order. On a push all cells compare against the broadcast value
// and larger ones shift one place right; a pop shifts every cell
// one place left. One item is accepted per cycle; its result (new head, empty
// flag, count, status) appears in the output register on the next cycle, and the
// block keeps accepting as long as that register is free or being taken.
// A push into a full queue is dropped with status 1; a pop on empty gives status 2.
// Depends on smpq_pkg and smpq_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_min_priority_queue (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_func,
    input  wire logic signed [smpq_pkg::DATA_W-1:0] s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [smpq_pkg::DATA_W-1:0]      m_head_value,
    output logic                                    m_is_empty,
    output logic [smpq_pkg::OCC_W-1:0]              m_occupancy,
    output logic [1:0]                              m_status
);
    import smpq_pkg::*;

    logic [CNT_W-1:0]         held_count_reg, held_count_next;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] head_reg, head_next;
    logic                     empty_reg;
    logic [OCC_W-1:0]         occ_reg;
    status_t                  status_reg, status_next;

    logic                     accept;
    logic                     is_pop, is_full, is_zero;
    cell_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      cell_keep;
    logic [CAPACITY-1:0]      cell_occ;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_pop  = (s_func == FUNC_POP);
    assign is_full = (held_count_reg == CNT_W'(CAPACITY));
    assign is_zero = (held_count_reg == '0);

    assign ctrl.ins   = accept && !is_pop && !is_full;
    assign ctrl.rem   = accept && is_pop && !is_zero;
    assign ctrl.value = s_value;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                     lk;
        logic signed [DATA_W-1:0] ld, rd;

        assign cell_occ[i] = (CNT_W'(i) < held_count_reg);

        if (i == 0) begin : g_first
            assign lk = 1'b1;
            assign ld = s_value;
        end else begin : g_mid
            assign lk = cell_keep[i-1];
            assign ld = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign rd = cell_data[i];
        end else begin : g_inner
            assign rd = cell_data[i+1];
        end

        smpq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .left_keep  (lk),
            .left_data  (ld),
            .right_data (rd),
            .data       (cell_data[i]),
            .keep       (cell_keep[i])
        );
    end

    always_comb begin
        held_count_next = held_count_reg;
        status_next     = ST_DONE;
        head_next       = is_zero ? '0 : cell_data[0];
        if (!is_pop) begin
            if (is_full) begin
                status_next = ST_FULL;
            end else begin
                held_count_next = held_count_reg + CNT_W'(1);
                if (!cell_keep[0]) begin
                    head_next = s_value;
                end
            end
        end else begin
            if (is_zero) begin
                status_next = ST_EMPTY;
            end else begin
                held_count_next = held_count_reg - CNT_W'(1);
                head_next       = (held_count_reg > CNT_W'(1)) ? cell_data[1] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                held_count_reg <= held_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // Result payload, hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            head_reg   <= head_next;
            empty_reg  <= (held_count_next == '0);
            occ_reg    <= OCC_W'(held_count_next);
            status_reg <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_head_value = head_reg;
    assign m_is_empty   = empty_reg;
    assign m_occupancy  = occ_reg;
    assign m_status     = status_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_pop && is_full |=> m_status == ST_FULL && $stable(held_count_reg))
        else $error("push on full not dropped");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_pop && is_zero |=> m_status == ST_EMPTY && m_is_empty)
        else $error("pop on empty mishandled");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_pop && !is_full |=>
            held_count_reg == $past(held_count_reg) + CNT_W'(1) && !m_is_empty)
        else $error("push did not grow the queue");
`endif

endmodule

`default_nettype wire
